// ===== hw/rtl/ssi_pkg.sv =====
// Shared definitions for the segment intersection pipeline.
// Default widths and the control record handed from stage to stage.
// No dependencies.
package ssi_pkg;

   localparam int COORD_BITS_DEF      = 16;
   localparam int PARAM_FRAC_BITS_DEF = 16;

   // per-beat control that travels alongside the datapath
   typedef struct packed {
      logic valid;
      logic hit;
   } ssi_ctl_type;

endpackage

// ===== hw/rtl/ssi_front.sv =====
// Front end of the intersection pipeline: edge vectors, cross products,
// determinant sign fix and the range test on both parameters. Five stages.
// Depends on ssi_pkg.
module ssi_front
   import ssi_pkg::*;
#(
   parameter int W = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [W-1:0]   fsx,
   input  logic signed [W-1:0]   fsy,
   input  logic signed [W-1:0]   fex,
   input  logic signed [W-1:0]   fey,
   input  logic signed [W-1:0]   osx,
   input  logic signed [W-1:0]   osy,
   input  logic signed [W-1:0]   oex,
   input  logic signed [W-1:0]   oey,
   output ssi_ctl_type           out_ctl,
   output logic [2*W+2:0]        num_mag,
   output logic [2*W+2:0]        den_mag,
   output logic signed [W-1:0]   out_os_x,
   output logic signed [W-1:0]   out_os_y,
   output logic signed [W:0]     out_dx,
   output logic signed [W:0]     out_dy
);

   localparam int PW     = 2*W + 2;
   localparam int DW     = 2*W + 3;
   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff;

   // sidebands carried to the interpolator
   logic signed [W-1:0] os_x_ff [STAGES];
   logic signed [W-1:0] os_y_ff [STAGES];
   logic signed [W:0]   dx_ff   [STAGES];
   logic signed [W:0]   dy_ff   [STAGES];

   // stage 1: edge vectors
   logic signed [W:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [W:0] ax_in, ay_in, bx_in, by_in, cx_in, cy_in, dx_in, dy_in;

   // stage 2: products
   logic signed [PW-1:0] p_aybx_ff, p_axby_ff, p_bycx_ff, p_bxcy_ff, p_axcy_ff, p_aycx_ff;
   logic signed [PW-1:0] p_aybx_in, p_axby_in, p_bycx_in, p_bxcy_in, p_axcy_in, p_aycx_in;

   // stage 3: determinant and numerators
   logic signed [DW-1:0] d_ff, ns_ff, nt_ff;
   logic signed [DW-1:0] d_in, ns_in, nt_in;

   // stage 4: sign normalised
   logic signed [DW-1:0] dm_ff, nsm_ff, ntm_ff;
   logic signed [DW-1:0] dm_in, nsm_in, ntm_in;
   logic                 zero_ff, zero_in;

   // stage 5: range test
   logic                 hit_ff, hit_in;
   logic [DW-1:0]        den_ff, num_ff;

   always_comb begin
      ax_in = (W+1)'(fex) - (W+1)'(fsx);
      ay_in = (W+1)'(fey) - (W+1)'(fsy);
      bx_in = (W+1)'(osx) - (W+1)'(oex);
      by_in = (W+1)'(osy) - (W+1)'(oey);
      cx_in = (W+1)'(fsx) - (W+1)'(osx);
      cy_in = (W+1)'(fsy) - (W+1)'(osy);
      dx_in = (W+1)'(oex) - (W+1)'(osx);
      dy_in = (W+1)'(oey) - (W+1)'(osy);
   end

   always_comb begin
      p_aybx_in = ay_ff * bx_ff;
      p_axby_in = ax_ff * by_ff;
      p_bycx_in = by_ff * cx_ff;
      p_bxcy_in = bx_ff * cy_ff;
      p_axcy_in = ax_ff * cy_ff;
      p_aycx_in = ay_ff * cx_ff;
   end

   always_comb begin
      d_in  = DW'(p_aybx_ff) - DW'(p_axby_ff);
      ns_in = DW'(p_bycx_ff) - DW'(p_bxcy_ff);
      nt_in = DW'(p_axcy_ff) - DW'(p_aycx_ff);
   end

   // flip all three when the determinant is negative
   always_comb begin
      zero_in = (d_ff == '0);
      if (d_ff[DW-1]) begin
         dm_in  = -d_ff;
         nsm_in = -ns_ff;
         ntm_in = -nt_ff;
      end else begin
         dm_in  = d_ff;
         nsm_in = ns_ff;
         ntm_in = nt_ff;
      end
   end

   always_comb begin
      hit_in = !zero_ff && !nsm_ff[DW-1] && !ntm_ff[DW-1]
               && (nsm_ff <= dm_ff) && (ntm_ff <= dm_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;

         p_aybx_ff <= p_aybx_in;
         p_axby_ff <= p_axby_in;
         p_bycx_ff <= p_bycx_in;
         p_bxcy_ff <= p_bxcy_in;
         p_axcy_ff <= p_axcy_in;
         p_aycx_ff <= p_aycx_in;

         d_ff  <= d_in;
         ns_ff <= ns_in;
         nt_ff <= nt_in;

         dm_ff   <= dm_in;
         nsm_ff  <= nsm_in;
         ntm_ff  <= ntm_in;
         zero_ff <= zero_in;

         hit_ff <= hit_in;
         den_ff <= $unsigned(dm_ff);
         num_ff <= $unsigned(ntm_ff);

         os_x_ff[0] <= osx;
         os_y_ff[0] <= osy;
         dx_ff[0]   <= dx_in;
         dy_ff[0]   <= dy_in;
         for (int k = 1; k < STAGES; k++) begin
            os_x_ff[k] <= os_x_ff[k-1];
            os_y_ff[k] <= os_y_ff[k-1];
            dx_ff[k]   <= dx_ff[k-1];
            dy_ff[k]   <= dy_ff[k-1];
         end
      end
   end

   assign out_ctl.valid = valid_ff[STAGES-1];
   assign out_ctl.hit   = hit_ff;
   assign num_mag       = num_ff;
   assign den_mag       = den_ff;
   assign out_os_x      = os_x_ff[STAGES-1];
   assign out_os_y      = os_y_ff[STAGES-1];
   assign out_dx        = dx_ff[STAGES-1];
   assign out_dy        = dy_ff[STAGES-1];

endmodule

// ===== hw/rtl/ssi_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, F+1 stages.
// Forms t = num/den with F fraction bits for 0 <= num <= den. Depends on ssi_pkg.
module ssi_div
   import ssi_pkg::*;
#(
   parameter int W = COORD_BITS_DEF,
   parameter int F = PARAM_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  ssi_ctl_type           in_ctl,
   input  logic [2*W+2:0]        num,
   input  logic [2*W+2:0]        den,
   input  logic signed [W-1:0]   in_os_x,
   input  logic signed [W-1:0]   in_os_y,
   input  logic signed [W:0]     in_dx,
   input  logic signed [W:0]     in_dy,
   output ssi_ctl_type           out_ctl,
   output logic [F:0]            quot,
   output logic signed [W-1:0]   out_os_x,
   output logic signed [W-1:0]   out_os_y,
   output logic signed [W:0]     out_dx,
   output logic signed [W:0]     out_dy
);

   localparam int DW = 2*W + 3;
   localparam int NS = F + 1;

   logic [NS-1:0]       valid_ff;
   logic [NS-1:0]       hit_ff;
   logic [DW-1:0]       r_ff    [NS];
   logic [DW-1:0]       d_ff    [NS];
   logic [F:0]          q_ff    [NS];
   logic signed [W-1:0] os_x_ff [NS];
   logic signed [W-1:0] os_y_ff [NS];
   logic signed [W:0]   dx_ff   [NS];
   logic signed [W:0]   dy_ff   [NS];

   logic [DW-1:0] r_src [NS];
   logic [DW-1:0] d_src [NS];
   logic [F:0]    q_src [NS];
   logic [NS-1:0] ge;

   // first stage takes the integer bit without a shift
   always_comb begin
      r_src[0] = num;
      d_src[0] = den;
      q_src[0] = '0;
      for (int k = 1; k < NS; k++) begin
         r_src[k] = r_ff[k-1] << 1;
         d_src[k] = d_ff[k-1];
         q_src[k] = q_ff[k-1] << 1;
      end
      for (int k = 0; k < NS; k++) begin
         ge[k] = (r_src[k] >= d_src[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-2:0], in_ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NS; k++) begin
            r_ff[k] <= ge[k] ? (r_src[k] - d_src[k]) : r_src[k];
            q_ff[k] <= q_src[k] | (F+1)'(ge[k]);
            d_ff[k] <= d_src[k];
         end
         hit_ff     <= {hit_ff[NS-2:0], in_ctl.hit};
         os_x_ff[0] <= in_os_x;
         os_y_ff[0] <= in_os_y;
         dx_ff[0]   <= in_dx;
         dy_ff[0]   <= in_dy;
         for (int k = 1; k < NS; k++) begin
            os_x_ff[k] <= os_x_ff[k-1];
            os_y_ff[k] <= os_y_ff[k-1];
            dx_ff[k]   <= dx_ff[k-1];
            dy_ff[k]   <= dy_ff[k-1];
         end
      end
   end

   assign out_ctl.valid = valid_ff[NS-1];
   assign out_ctl.hit   = hit_ff[NS-1];
   assign quot          = q_ff[NS-1];
   assign out_os_x      = os_x_ff[NS-1];
   assign out_os_y      = os_y_ff[NS-1];
   assign out_dx        = dx_ff[NS-1];
   assign out_dy        = dy_ff[NS-1];

endmodule

// ===== hw/rtl/ssi_lerp.sv =====
// Interpolation along the second segment: multiply stage, then round to
// nearest (halves up), offset and zero on miss into the output register. Depends on ssi_pkg.
module ssi_lerp
   import ssi_pkg::*;
#(
   parameter int W = COORD_BITS_DEF,
   parameter int F = PARAM_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  ssi_ctl_type           in_ctl,
   input  logic [F:0]            t,
   input  logic signed [W-1:0]   in_os_x,
   input  logic signed [W-1:0]   in_os_y,
   input  logic signed [W:0]     in_dx,
   input  logic signed [W:0]     in_dy,
   output logic                  out_valid,
   output logic                  out_hit,
   output logic signed [W-1:0]   out_x,
   output logic signed [W-1:0]   out_y
);

   localparam int MW = W + F + 3;
   localparam logic signed [MW-1:0] HALF = MW'(1) <<< (F-1);

   logic                 ctl_valid_ff, ctl_hit_ff;
   logic signed [W-1:0]  os_x_ff, os_y_ff;
   logic signed [MW-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [F+1:0]  t_s;

   logic                 valid_ff, hit_ff;
   logic signed [W-1:0]  x_ff, y_ff;
   logic signed [MW-1:0] sx, sy, fx, fy;

   assign t_s = $signed({1'b0, t});

   always_comb begin
      px_in = in_dx * t_s;
      py_in = in_dy * t_s;
   end

   // floor((p + half) / 2^F) + start
   always_comb begin
      sx = px_ff + HALF;
      sy = py_ff + HALF;
      fx = MW'(os_x_ff) + (sx >>> F);
      fy = MW'(os_y_ff) + (sy >>> F);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (en) begin
         ctl_valid_ff <= in_ctl.valid;
         valid_ff     <= ctl_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_hit_ff <= in_ctl.hit;
         os_x_ff    <= in_os_x;
         os_y_ff    <= in_os_y;
         px_ff      <= px_in;
         py_ff      <= py_in;
         hit_ff     <= ctl_hit_ff;
         x_ff       <= ctl_hit_ff ? fx[W-1:0] : '0;
         y_ff       <= ctl_hit_ff ? fy[W-1:0] : '0;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule

// ===== hw/rtl/segment_segment_intersection.sv =====
// Two-segment intersection, pipelined from input beat to result beat: 5 front stages,
// PARAM_FRAC_BITS + 1 divider stages (one per quotient bit), 2 interpolation stages.
// Throughput one beat per cycle; the only stall is back-pressure on the result side,
// which freezes the whole pipeline.
// Synchronous reset empties the pipeline; there is no other state.
module segment_segment_intersection
   import ssi_pkg::*;
#(
   parameter int COORD_BITS      = COORD_BITS_DEF,
   parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // other_start_x, other_start_y, other_end_x, other_end_y
   input  logic [8*COORD_BITS-1:0]                req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // cross_x, cross_y, zero fill
   output logic [((2*COORD_BITS+7)/8)*8-1:0]      rsp_tdata,
   // hit
   output logic [0:0]                             rsp_tuser
);

   localparam int W   = COORD_BITS;
   localparam int F   = PARAM_FRAC_BITS;
   localparam int DW  = 2*W + 3;
   localparam int RDW = ((2*W+7)/8)*8;

   logic en;

   ssi_ctl_type         f_ctl, d_ctl;
   logic [DW-1:0]       f_num, f_den;
   logic signed [W-1:0] f_os_x, f_os_y, d_os_x, d_os_y;
   logic signed [W:0]   f_dx, f_dy, d_dx, d_dy;
   logic [F:0]          d_t;
   logic                l_hit;
   logic signed [W-1:0] l_x, l_y;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   ssi_front #(.W(W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .fsx      ($signed(req_tdata[0*W +: W])),
      .fsy      ($signed(req_tdata[1*W +: W])),
      .fex      ($signed(req_tdata[2*W +: W])),
      .fey      ($signed(req_tdata[3*W +: W])),
      .osx      ($signed(req_tdata[4*W +: W])),
      .osy      ($signed(req_tdata[5*W +: W])),
      .oex      ($signed(req_tdata[6*W +: W])),
      .oey      ($signed(req_tdata[7*W +: W])),
      .out_ctl  (f_ctl),
      .num_mag  (f_num),
      .den_mag  (f_den),
      .out_os_x (f_os_x),
      .out_os_y (f_os_y),
      .out_dx   (f_dx),
      .out_dy   (f_dy)
   );

   ssi_div #(.W(W), .F(F)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (f_ctl),
      .num      (f_num),
      .den      (f_den),
      .in_os_x  (f_os_x),
      .in_os_y  (f_os_y),
      .in_dx    (f_dx),
      .in_dy    (f_dy),
      .out_ctl  (d_ctl),
      .quot     (d_t),
      .out_os_x (d_os_x),
      .out_os_y (d_os_y),
      .out_dx   (d_dx),
      .out_dy   (d_dy)
   );

   ssi_lerp #(.W(W), .F(F)) u_lerp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (d_ctl),
      .t         (d_t),
      .in_os_x   (d_os_x),
      .in_os_y   (d_os_y),
      .in_dx     (d_dx),
      .in_dy     (d_dy),
      .out_valid (rsp_tvalid),
      .out_hit   (l_hit),
      .out_x     (l_x),
      .out_y     (l_y)
   );

   assign rsp_tdata    = RDW'({l_y, l_x});
   assign rsp_tuser[0] = l_hit;

   // a miss always carries a zero point
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss beat with non-zero point");

   // nothing comes out in the cycle after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat straight after reset");

   // input is held off only by a waiting result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without back-pressure");

   // a frozen pipeline keeps its result
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tuser))
      else $error("result lost under back-pressure");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for segment_segment_intersection: drives segment pairs on the
// request stream with random gaps and back-pressure, and checks every result beat.
// Depends on ssi_pkg and the segment_segment_intersection RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ssi_pkg::*;

   localparam int CW        = COORD_BITS_DEF;
   localparam int FRAC      = PARAM_FRAC_BITS_DEF;
   localparam int LATENCY   = FRAC + 8;
   localparam int RAND_ITEMS = 1000;
   localparam int LONG_HOLD = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic signed [CW-1:0] coord_type;

   // reversed member order so that first_start_x lands in the lowest bits of tdata
   typedef struct packed {
      coord_type oey, oex, osy, osx;
      coord_type fey, fex, fsy, fsx;
   } segment_pair_type;

   typedef struct {
      logic      hit;
      coord_type x;
      coord_type y;
   } crossing_type;

   class crossing_scoreboard;
      crossing_type pending_crossings[$];
      int mismatches, crossings, misses, parallels, checked;

      function crossing_type predict_crossing(segment_pair_type p);
         crossing_type res;
         longint ax, ay, bx, by, cx, cy, det, ns, nt, q, r;
         res = '{hit: 1'b0, x: '0, y: '0};
         ax = longint'(p.fex) - longint'(p.fsx);
         ay = longint'(p.fey) - longint'(p.fsy);
         bx = longint'(p.osx) - longint'(p.oex);
         by = longint'(p.osy) - longint'(p.oey);
         cx = longint'(p.fsx) - longint'(p.osx);
         cy = longint'(p.fsy) - longint'(p.osy);
         det = ay * bx - ax * by;
         if (det == 0) begin
            parallels++;
            misses++;
            return res;
         end
         ns = by * cx - bx * cy;
         nt = ax * cy - ay * cx;
         if (det < 0) begin
            det = -det;
            ns = -ns;
            nt = -nt;
         end
         if (ns < 0 || ns > det || nt < 0 || nt > det) begin
            misses++;
            return res;
         end
         // restoring division of nt by det, one integer bit plus FRAC fraction bits
         q = 0;
         r = nt;
         if (r >= det) begin
            q = 1;
            r -= det;
         end
         for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= det) begin
               r -= det;
               q |= 1;
            end
         end
         res.hit = 1'b1;
         // arithmetic shift floors, so adding a half rounds halves upwards
         res.x = coord_type'(longint'(p.osx)
                 + (((longint'(p.oex) - longint'(p.osx)) * q + (longint'(1) << (FRAC-1)))
                    >>> FRAC));
         res.y = coord_type'(longint'(p.osy)
                 + (((longint'(p.oey) - longint'(p.osy)) * q + (longint'(1) << (FRAC-1)))
                    >>> FRAC));
         crossings++;
         return res;
      endfunction

      function void note_pair(segment_pair_type p);
         pending_crossings.push_back(predict_crossing(p));
      endfunction

      function void check_crossing(logic hit, coord_type x, coord_type y);
         crossing_type exp_c;
         checked++;
         if (pending_crossings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing outstanding: hit=%0b x=%0d y=%0d",
                        $realtime, hit, x, y);
            return;
         end
         exp_c = pending_crossings.pop_front();
         if (hit !== exp_c.hit || x !== exp_c.x || y !== exp_c.y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                        $realtime, exp_c.hit, exp_c.x, exp_c.y, hit, x, y);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [8*CW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [((2*CW+7)/8)*8-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   crossing_scoreboard board = new();
   bit hold_request = 1'b0;
   bit steady = 1'b0;
   int cycle_count = 0;
   int stall_beats = 0;

   always #2 clock = ~clock;

   segment_segment_intersection i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic int rand_signed(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 60)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic segment_pair_type make_pair(int fsx, int fsy, int fex, int fey,
                                                  int osx, int osy, int oex, int oey);
      segment_pair_type p;
      p.fsx = coord_type'(fsx);
      p.fsy = coord_type'(fsy);
      p.fex = coord_type'(fex);
      p.fey = coord_type'(fey);
      p.osx = coord_type'(osx);
      p.osy = coord_type'(osy);
      p.oex = coord_type'(oex);
      p.oey = coord_type'(oey);
      return p;
   endfunction

   // Most pairs are built to meet at a chosen point, with the meeting parameter set
   // by the ratio of whole multiples along each direction; some get a one-lsb nudge
   // to land just either side of an endpoint. The rest are parallel or pure noise.
   function automatic segment_pair_type random_pair();
      segment_pair_type p;
      int pick, scale, px, py, ux, uy, wx, wy, n1, n2, m1, m2, span;
      pick = $urandom_range(0, 99);
      if (pick >= 80) begin
         p = segment_pair_type'({$urandom(), $urandom(), $urandom(), $urandom()});
         return p;
      end
      case ($urandom_range(0, 2))
         0: scale = 8;
         1: scale = 256;
         default: scale = 5461;
      endcase
      span = 32766 - 3 * scale;
      px = rand_signed(span);
      py = rand_signed(span);
      ux = rand_signed(scale);
      uy = rand_signed(scale);
      wx = rand_signed(scale);
      wy = rand_signed(scale);
      n1 = $urandom_range(0, 3);
      n2 = $urandom_range(0, 3);
      m1 = $urandom_range(0, 3);
      m2 = $urandom_range(0, 3);
      if (pick >= 75) begin
         // same direction, offset sideways: parallel or collinear
         return make_pair(px + ux*n1, py + uy*n1, px - ux*n2, py - uy*n2,
                          px + ux*m1 + wx, py + uy*m1 + wy,
                          px - ux*m2 + wx, py - uy*m2 + wy);
      end
      p = make_pair(px + ux*n1, py + uy*n1, px - ux*n2, py - uy*n2,
                    px + wx*m1, py + wy*m1, px - wx*m2, py - wy*m2);
      if (pick >= 60) begin
         case ($urandom_range(0, 7))
            0: p.fsx += coord_type'(rand_signed(1));
            1: p.fsy += coord_type'(rand_signed(1));
            2: p.fex += coord_type'(rand_signed(1));
            3: p.fey += coord_type'(rand_signed(1));
            4: p.osx += coord_type'(rand_signed(1));
            5: p.osy += coord_type'(rand_signed(1));
            6: p.oex += coord_type'(rand_signed(1));
            default: p.oey += coord_type'(rand_signed(1));
         endcase
      end
      return p;
   endfunction

   task automatic send_pair(segment_pair_type p);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_pair(p);
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_crossings();
      req_tvalid <= 1'b0;
      while (board.pending_crossings.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("segment_segment_intersection regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_crossing(rsp_tuser[0], coord_type'(rsp_tdata[CW-1:0]),
                              coord_type'(rsp_tdata[2*CW-1:CW]));
      if (!reset && req_tvalid && !req_tready)
         stall_beats <= stall_beats + 1;
   end

   // result side: random ready runs and stalls, plus one long hold-off on request
   initial begin
      int run, stall;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (steady) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            run = $urandom_range(1, 20);
            rsp_tready <= 1'b1;
            repeat (run) @(posedge clock);
            stall = gap_len();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin
      segment_pair_type directed[$];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
      directed.push_back(make_pair(0, 160, 160, 0, 0, 0, 160, 160));
      directed.push_back(make_pair(0, 0, 100, 0, 0, 50, 100, 50));       // parallel
      directed.push_back(make_pair(0, 0, 100, 0, 50, 0, 150, 0));        // collinear
      directed.push_back(make_pair(5, 5, 5, 5, 0, 0, 10, 10));           // zero length
      directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(0, 0, 100, 0, 50, 0, 50, 100));       // touch, t = 0
      directed.push_back(make_pair(0, 0, 100, 0, 50, 100, 50, 0));       // touch, t = 1
      directed.push_back(make_pair(50, 0, 50, 100, 0, 0, 100, 0));       // touch, s = 0
      directed.push_back(make_pair(50, 100, 50, 0, 0, 0, 100, 0));       // touch, s = 1
      directed.push_back(make_pair(0, 0, 10, 10, 100, 0, 0, 100));       // beyond first
      directed.push_back(make_pair(0, 0, 100, 100, 60, 0, 100, -40));    // behind second
      directed.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      directed.push_back(make_pair(-32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767));
      directed.push_back(make_pair(32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768));
      directed.push_back(make_pair(1, -10, 1, 10, 0, 0, 3, 3));          // t = 1/3
      directed.push_back(make_pair(-100, -7, -3, 50, -90, 40, -1, -33));
      directed.push_back(make_pair(-5, 1, 5, 1, 0, 0, 1, 2));            // rounds half up
      directed.push_back(make_pair(-5, 1, 5, 1, 0, 0, -1, 2));           // half, negative
      directed.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      directed.push_back(make_pair(-32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
      foreach (directed[i])
         send_pair(directed[i]);
      drain_crossings();

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == 100)
            hold_request = 1'b1;
         if (n == 400)
            steady = 1'b1;
         if (n == 550) begin
            steady = 1'b0;
            drain_crossings();
         end
         send_pair(random_pair());
      end

      drain_crossings();
      repeat (2 * LATENCY) @(posedge clock);
      $display("checked %0d result beats: %0d crossings, %0d misses (%0d parallel or degenerate)",
               board.checked, board.crossings, board.misses, board.parallels);
      $display("request side held off for %0d cycles under result back-pressure; %0d mismatches",
               stall_beats, board.mismatches);
      if (board.mismatches == 0)
         $display("segment_segment_intersection regression: pass");
      else
         $display("segment_segment_intersection regression: fail");
      $finish;
   end

endmodule

// ===== segment_segment_intersection.f =====
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_front.sv
hw/rtl/ssi_div.sv
hw/rtl/ssi_lerp.sv
hw/rtl/segment_segment_intersection.sv
tb/testbench.sv
